// ===== rtl/core/rpas_pkg.sv =====
// ---------------------------------------------------------------------------
// rpas_pkg: shared types and constants for the residue pair alignment scorer
// Field widths, residue group masks, pair classes and register indexes.
// ---------------------------------------------------------------------------
package rpas_pkg;

    localparam int LETTER_W    = 8;
    localparam int OFFSET_W    = 12;
    localparam int WEIGHT_W    = 16;
    localparam int COUNT_W     = 13;
    localparam int SCORE_W     = 29;
    localparam int NUM_CLASS   = 4;
    localparam int ALPHA_N     = 26;
    localparam int NUM_CONS    = 9;
    localparam int NUM_SEMI    = 11;
    localparam int CFG_ADDR_W  = 4;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 96;
    localparam int MAX_LEN_DEF = 4096;
    localparam int SCORE_LIMIT = 268431360;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

    // class order also gives the weight register order
    typedef enum logic [1:0] {
        CLASS_STAR  = 2'd0,
        CLASS_COLON = 2'd1,
        CLASS_POINT = 2'd2,
        CLASS_SPACE = 2'd3
    } class_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WEIGHT_STAR  = 4'd0,
        REG_WEIGHT_COLON = 4'd1,
        REG_WEIGHT_POINT = 4'd2,
        REG_WEIGHT_SPACE = 4'd3
    } cfg_reg_t;

    typedef logic [ALPHA_N-1:0] letter_set_t;

    // one-hot position of an upper-case letter, empty for any other byte
    function automatic letter_set_t letter_bit(input logic [LETTER_W-1:0] c);
        letter_set_t r;
        r = '0;
        if (c >= "A" && c <= "Z") begin
            r = letter_set_t'(1) << (c - LETTER_W'("A"));
        end
        return r;
    endfunction

    localparam letter_set_t CONS_GROUPS [NUM_CONS] = '{
        letter_bit("N") | letter_bit("D") | letter_bit("E") | letter_bit("Q"),
        letter_bit("N") | letter_bit("E") | letter_bit("Q") | letter_bit("K"),
        letter_bit("S") | letter_bit("T") | letter_bit("A"),
        letter_bit("M") | letter_bit("I") | letter_bit("L") | letter_bit("V"),
        letter_bit("Q") | letter_bit("H") | letter_bit("R") | letter_bit("K"),
        letter_bit("N") | letter_bit("H") | letter_bit("Q") | letter_bit("K"),
        letter_bit("F") | letter_bit("Y") | letter_bit("W"),
        letter_bit("H") | letter_bit("Y"),
        letter_bit("M") | letter_bit("I") | letter_bit("L") | letter_bit("F")
    };

    localparam letter_set_t SEMI_GROUPS [NUM_SEMI] = '{
        letter_bit("S") | letter_bit("A") | letter_bit("G"),
        letter_bit("A") | letter_bit("T") | letter_bit("V"),
        letter_bit("C") | letter_bit("S") | letter_bit("A"),
        letter_bit("S") | letter_bit("G") | letter_bit("N") | letter_bit("D"),
        letter_bit("S") | letter_bit("T") | letter_bit("P") | letter_bit("A"),
        letter_bit("S") | letter_bit("T") | letter_bit("N") | letter_bit("K"),
        letter_bit("N") | letter_bit("E") | letter_bit("Q") | letter_bit("H")
            | letter_bit("R") | letter_bit("K"),
        letter_bit("N") | letter_bit("D") | letter_bit("E") | letter_bit("Q")
            | letter_bit("H") | letter_bit("K"),
        letter_bit("S") | letter_bit("N") | letter_bit("D") | letter_bit("E")
            | letter_bit("Q") | letter_bit("K"),
        letter_bit("H") | letter_bit("F") | letter_bit("Y"),
        letter_bit("F") | letter_bit("V") | letter_bit("L") | letter_bit("I")
            | letter_bit("M")
    };

endpackage

// ===== rtl/core/rpas_classify.sv =====
// ---------------------------------------------------------------------------
// rpas_classify: residue pair classifier
// Sorts one letter pair into identical, conservative, semi-conservative or other.
// ---------------------------------------------------------------------------
module rpas_classify
    import rpas_pkg::*;
(
    input  logic [LETTER_W-1:0] letter_a,
    input  logic [LETTER_W-1:0] letter_b,
    output class_t              pair_class
);

    letter_set_t set_a;
    letter_set_t set_b;
    logic        cons_hit;
    logic        semi_hit;

    assign set_a = letter_bit(letter_a);
    assign set_b = letter_bit(letter_b);

    // bytes outside A..Z give an empty set and never hit a group
    always_comb begin
        cons_hit = 1'b0;
        semi_hit = 1'b0;
        for (int g = 0; g < NUM_CONS; g++) begin
            if (|(CONS_GROUPS[g] & set_a) && |(CONS_GROUPS[g] & set_b)) begin
                cons_hit = 1'b1;
            end
        end
        for (int g = 0; g < NUM_SEMI; g++) begin
            if (|(SEMI_GROUPS[g] & set_a) && |(SEMI_GROUPS[g] & set_b)) begin
                semi_hit = 1'b1;
            end
        end
    end

    always_comb begin
        if (letter_a == letter_b) begin
            pair_class = CLASS_STAR;
        end else if (cons_hit) begin
            pair_class = CLASS_COLON;
        end else if (semi_hit) begin
            pair_class = CLASS_POINT;
        end else begin
            pair_class = CLASS_SPACE;
        end
    end

endmodule

// ===== rtl/core/rpas_counter_bank.sv =====
// ---------------------------------------------------------------------------
// rpas_counter_bank: input register, class counters and run snapshot
// Counts each pair into its class; a last pair hands the totals downstream.
// ---------------------------------------------------------------------------
module rpas_counter_bank
    import rpas_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int CNT_W   = $clog2(MAX_LEN + 1)
)
(
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [LETTER_W-1:0]                in_letter_a,
    input  logic [LETTER_W-1:0]                in_letter_b,
    input  logic [OFFSET_W-1:0]                in_offset,
    input  logic                               in_last,
    output logic                               snap_valid,
    input  logic                               snap_ready,
    output logic [NUM_CLASS-1:0][CNT_W-1:0]    snap_count,
    output logic [OFFSET_W-1:0]                snap_offset
);

    logic                            pair_valid_reg;
    logic [LETTER_W-1:0]             letter_a_reg;
    logic [LETTER_W-1:0]             letter_b_reg;
    logic [OFFSET_W-1:0]             offset_reg;
    logic                            last_reg;
    logic                            pair_move;
    class_t                          pair_class;
    logic [NUM_CLASS-1:0][CNT_W-1:0] count_reg;
    logic [NUM_CLASS-1:0][CNT_W-1:0] count_next;
    logic [NUM_CLASS-1:0][CNT_W-1:0] bumped;
    logic                            snap_valid_reg;
    logic                            snap_valid_next;
    logic [NUM_CLASS-1:0][CNT_W-1:0] snap_count_reg;
    logic [OFFSET_W-1:0]             snap_offset_reg;

    rpas_classify u_classify (
        .letter_a   (letter_a_reg),
        .letter_b   (letter_b_reg),
        .pair_class (pair_class)
    );

    // a pair that does not end the run never waits on the snapshot
    assign pair_move = pair_valid_reg && (!last_reg || !snap_valid_reg || snap_ready);
    assign in_ready  = !pair_valid_reg || pair_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
        end else if (in_ready) begin
            pair_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            letter_a_reg <= in_letter_a;
            letter_b_reg <= in_letter_b;
            offset_reg   <= in_offset;
            last_reg     <= in_last;
        end
    end

    // saturating increment of the hit class
    always_comb begin
        for (int i = 0; i < NUM_CLASS; i++) begin
            bumped[i] = count_reg[i];
            if (int'(pair_class) == i && count_reg[i] < CNT_W'(MAX_LEN)) begin
                bumped[i] = count_reg[i] + CNT_W'(1);
            end
        end
        count_next = count_reg;
        if (pair_move) begin
            count_next = last_reg ? '0 : bumped;
        end
        snap_valid_next = snap_valid_reg;
        if (snap_valid_reg && snap_ready) begin
            snap_valid_next = 1'b0;
        end
        if (pair_move && last_reg) begin
            snap_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pair_move && last_reg) begin
            snap_count_reg  <= bumped;
            snap_offset_reg <= offset_reg;
        end
    end

    assign snap_valid  = snap_valid_reg;
    assign snap_count  = snap_count_reg;
    assign snap_offset = snap_offset_reg;

    for (genvar k = 0; k < NUM_CLASS; k++) begin : g_sat_check
        a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
            count_reg[k] <= CNT_W'(MAX_LEN))
            else $error("class counter above its saturation limit");
    end

    a_clear_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (pair_move && last_reg) |=> (count_reg == '0))
        else $error("counters not cleared after the last pair");

    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && !snap_ready) |=> (snap_valid_reg && $stable(snap_count_reg)))
        else $error("run snapshot changed while stalled");

endmodule

// ===== rtl/core/rpas_score.sv =====
// ---------------------------------------------------------------------------
// rpas_score: weighted score of one run
// Registered products of weights and counts, then the signed sum and clamp.
// ---------------------------------------------------------------------------
module rpas_score
    import rpas_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int CNT_W   = $clog2(MAX_LEN + 1)
)
(
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [NUM_CLASS-1:0][WEIGHT_W-1:0] weight,
    input  logic                               snap_valid,
    output logic                               snap_ready,
    input  logic [NUM_CLASS-1:0][CNT_W-1:0]    snap_count,
    input  logic [OFFSET_W-1:0]                snap_offset,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [SCORE_W-1:0]                 out_score,
    output logic [NUM_CLASS-1:0][COUNT_W-1:0]  out_count,
    output logic [OFFSET_W-1:0]                out_offset
);

    localparam int PROD_W = WEIGHT_W + CNT_W;
    localparam int SUM_W  = (PROD_W + 3 > SCORE_W + 1) ? PROD_W + 3 : SCORE_W + 1;
    localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(SCORE_LIMIT);

    logic                             prod_valid_reg;
    logic [NUM_CLASS-1:0][PROD_W-1:0] prod_reg;
    logic [NUM_CLASS-1:0][CNT_W-1:0]  prod_count_reg;
    logic [OFFSET_W-1:0]              prod_offset_reg;
    logic                             prod_move;
    logic signed [SUM_W-1:0]          sum;
    logic signed [SUM_W-1:0]          clamped;
    logic [CNT_W+COUNT_W-1:0]         count_ext;
    logic [NUM_CLASS-1:0][COUNT_W-1:0] count_trim;
    logic                             out_valid_reg;
    logic [SCORE_W-1:0]               score_reg;
    logic [NUM_CLASS-1:0][COUNT_W-1:0] count_out_reg;
    logic [OFFSET_W-1:0]              offset_out_reg;

    assign prod_move  = prod_valid_reg && (!out_valid_reg || out_ready);
    assign snap_ready = !prod_valid_reg || prod_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (snap_ready) begin
            prod_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            for (int i = 0; i < NUM_CLASS; i++) begin
                prod_reg[i] <= PROD_W'(weight[i]) * PROD_W'(snap_count[i]);
            end
            prod_count_reg  <= snap_count;
            prod_offset_reg <= snap_offset;
        end
    end

    // star product minus the three penalties, wide enough never to wrap
    always_comb begin
        sum = SUM_W'(prod_reg[CLASS_STAR]) - SUM_W'(prod_reg[CLASS_COLON])
            - SUM_W'(prod_reg[CLASS_POINT]) - SUM_W'(prod_reg[CLASS_SPACE]);
        if (sum > LIMIT) begin
            clamped = LIMIT;
        end else if (sum < -LIMIT) begin
            clamped = -LIMIT;
        end else begin
            clamped = sum;
        end
    end

    always_comb begin
        count_ext = '0;
        for (int i = 0; i < NUM_CLASS; i++) begin
            count_ext     = (CNT_W + COUNT_W)'(prod_count_reg[i]);
            count_trim[i] = count_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_move) begin
            score_reg      <= clamped[SCORE_W-1:0];
            count_out_reg  <= count_trim;
            offset_out_reg <= prod_offset_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_score  = score_reg;
    assign out_count  = count_out_reg;
    assign out_offset = offset_out_reg;

    a_prod_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_valid_reg && !prod_move) |=> (prod_valid_reg && $stable(prod_reg)))
        else $error("product stage changed while stalled");

    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($signed(score_reg) <= SCORE_W'(SCORE_LIMIT)
            && $signed(score_reg) >= -$signed(SCORE_W'(SCORE_LIMIT))))
        else $error("score outside the clamp range");

    a_prod_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_move |=> out_valid_reg)
        else $error("product stage advanced without an output word");

endmodule

// ===== rtl/core/residue_pair_alignment_scorer.sv =====
// ---------------------------------------------------------------------------
// residue_pair_alignment_scorer: class counts and weighted score of a run
// Sorts residue pairs into four classes and scores each run on its last pair.
//
//   channel   dir  handshake          content
//   s_        in   tvalid/tready      one residue pair word, tlast ends run
//   m_        out  tvalid/tready      one word per run: score and counts
//   cfg_      in   cfg_wr_en          class weight write, no handshake
//
// One pair word is taken every cycle unless a last pair finds the run
// snapshot occupied; stages are input register, counters with run snapshot,
// weight products, score and output register.
// Reset clears counters and valid flags and sets every weight to 1.0.
// A stalled m_ side fills the pipe; pairs that do not end a run keep
// flowing until a last pair finds the snapshot still occupied.
// ---------------------------------------------------------------------------
module residue_pair_alignment_scorer
    import rpas_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // letter_a, letter_b, offset, zero pad
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // score, star_count, colon_count,
                                              // point_count, space_count,
                                              // run_offset, zero pad
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WEIGHT_W-1:0]   cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int PAD_W = M_TDATA_W - SCORE_W - NUM_CLASS * COUNT_W - OFFSET_W;

    logic [NUM_CLASS-1:0][WEIGHT_W-1:0] weight_reg;
    logic                               snap_valid;
    logic                               snap_ready;
    logic [NUM_CLASS-1:0][CNT_W-1:0]    snap_count;
    logic [OFFSET_W-1:0]                snap_offset;
    logic [SCORE_W-1:0]                 out_score;
    logic [NUM_CLASS-1:0][COUNT_W-1:0]  out_count;
    logic [OFFSET_W-1:0]                out_offset;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= {NUM_CLASS{WEIGHT_RESET}};
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WEIGHT_STAR:  weight_reg[CLASS_STAR]  <= cfg_wdata;
                REG_WEIGHT_COLON: weight_reg[CLASS_COLON] <= cfg_wdata;
                REG_WEIGHT_POINT: weight_reg[CLASS_POINT] <= cfg_wdata;
                REG_WEIGHT_SPACE: weight_reg[CLASS_SPACE] <= cfg_wdata;
                default: begin
                    // unknown register index, write dropped
                end
            endcase
        end
    end

    rpas_counter_bank #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_counter_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_letter_a (s_tdata[LETTER_W-1:0]),
        .in_letter_b (s_tdata[2*LETTER_W-1:LETTER_W]),
        .in_offset   (s_tdata[2*LETTER_W+OFFSET_W-1:2*LETTER_W]),
        .in_last     (s_tlast),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap_count  (snap_count),
        .snap_offset (snap_offset)
    );

    rpas_score #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_score (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .weight      (weight_reg),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap_count  (snap_count),
        .snap_offset (snap_offset),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_score   (out_score),
        .out_count   (out_count),
        .out_offset  (out_offset)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_offset, out_count, out_score};

endmodule
